@@ sv/idalloc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package idalloc_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int NUM_COUNT_W  = 11;
    localparam int NUMBER_W     = 10;
    localparam int CMD_W        = 2;

    localparam logic [NUM_COUNT_W-1:0] NUM_COUNT_RST = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [NUMBER_W-1:0] number;
    } in_item_t;

    typedef struct packed {
        logic                ok;
        logic [NUMBER_W-1:0] granted;
    } out_item_t;

    typedef struct packed {
        logic launch;
        logic execute;
        logic cfg_write;
    } ctrl_t;

endpackage

`default_nettype wire

@@ sv/idalloc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idalloc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           cfg_valid,
    output logic                busy,
    output logic                cfg_ready,
    output idalloc_pkg::ctrl_t  ctrl
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy           = busy_reg;
    assign cfg_ready      = (state_reg == ST_IDLE);
    assign ctrl.launch    = start && (state_reg == ST_IDLE);
    assign ctrl.execute   = (state_reg == ST_EXEC);
    assign ctrl.cfg_write = cfg_valid && (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ sv/idalloc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idalloc_datapath #(
    parameter int CAPACITY = idalloc_pkg::CAPACITY_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire idalloc_pkg::ctrl_t                    ctrl,
    input  wire idalloc_pkg::in_item_t                 req,
    input  wire logic [idalloc_pkg::NUM_COUNT_W-1:0]   cfg_data,
    output logic                                       done,
    output idalloc_pkg::out_item_t                     result
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > idalloc_pkg::NUM_COUNT_W) ? CNT_W : idalloc_pkg::NUM_COUNT_W;
    localparam int NUM_W  = idalloc_pkg::NUMBER_W;

    logic             fm_mem  [CAPACITY];
    logic [NUM_W-1:0] stk_mem [CAPACITY];

    logic [idalloc_pkg::NUM_COUNT_W-1:0] num_count_reg;
    logic [CNT_W-1:0]                    stack_depth_reg, stack_depth_next;
    logic [CNT_W-1:0]                    next_fresh_reg, next_fresh_next;
    logic                                done_reg;
    logic [idalloc_pkg::CMD_W-1:0]       cmd_reg;
    logic [NUM_W-1:0]                    number_reg;
    logic                                fm_rd_reg;
    logic [NUM_W-1:0]                    stk_rd_reg;
    idalloc_pkg::out_item_t              result_reg, result_next;

    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  num_ext;
    logic              in_range;
    logic              is_free;
    logic              fm_we;
    logic [ADDR_W-1:0] fm_waddr;
    logic              fm_wdata;
    logic              stk_we;

    always_comb
    begin
        limit = (CMP_W'(num_count_reg) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                           : CMP_W'(num_count_reg);
        num_ext  = CMP_W'(number_reg);
        in_range = num_ext < limit;
        // numbers at or above next_fresh were never handed out
        is_free  = (num_ext >= CMP_W'(next_fresh_reg)) ? 1'b1 : fm_rd_reg;

        stack_depth_next = stack_depth_reg;
        next_fresh_next  = next_fresh_reg;
        result_next.ok      = 1'b0;
        result_next.granted = '0;
        fm_we    = 1'b0;
        fm_waddr = ADDR_W'(number_reg);
        fm_wdata = 1'b0;
        stk_we   = 1'b0;

        case (cmd_reg)
            idalloc_pkg::CMD_GET:
            begin
                if (stack_depth_reg != '0)
                begin
                    stack_depth_next    = stack_depth_reg - CNT_W'(1);
                    fm_we               = 1'b1;
                    fm_waddr            = ADDR_W'(stk_rd_reg);
                    result_next.ok      = 1'b1;
                    result_next.granted = stk_rd_reg;
                end
                else if (CMP_W'(next_fresh_reg) < limit)
                begin
                    next_fresh_next     = next_fresh_reg + CNT_W'(1);
                    fm_we               = 1'b1;
                    fm_waddr            = ADDR_W'(next_fresh_reg);
                    result_next.ok      = 1'b1;
                    result_next.granted = NUM_W'(next_fresh_reg);
                end
            end
            idalloc_pkg::CMD_CHECK:
            begin
                result_next.ok = in_range && is_free;
            end
            idalloc_pkg::CMD_RELEASE:
            begin
                if (in_range && !is_free && (stack_depth_reg < CNT_W'(CAPACITY)))
                begin
                    stack_depth_next = stack_depth_reg + CNT_W'(1);
                    stk_we           = 1'b1;
                    fm_we            = 1'b1;
                    fm_wdata         = 1'b1;
                    result_next.ok   = 1'b1;
                end
            end
            default:
            begin
                result_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_count_reg   <= idalloc_pkg::NUM_COUNT_RST;
            stack_depth_reg <= '0;
            next_fresh_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.execute;
            if (ctrl.cfg_write)
            begin
                num_count_reg   <= cfg_data;
                stack_depth_reg <= '0;
                next_fresh_reg  <= '0;
            end
            else if (ctrl.execute)
            begin
                stack_depth_reg <= stack_depth_next;
                next_fresh_reg  <= next_fresh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.launch)
        begin
            cmd_reg    <= req.cmd;
            number_reg <= req.number;
            fm_rd_reg  <= fm_mem[ADDR_W'(req.number)];
            stk_rd_reg <= stk_mem[ADDR_W'(stack_depth_reg - CNT_W'(1))];
        end
        if (ctrl.execute)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute && fm_we)
        begin
            fm_mem[fm_waddr] <= fm_wdata;
        end
        if (ctrl.execute && stk_we)
        begin
            stk_mem[ADDR_W'(stack_depth_reg)] <= number_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ sv/id_allocator_free_stack_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Identifier allocator with a LIFO recycle stack.
// Command channel: an item (cmd, number) is taken at a clock edge where start
// is high and busy is low. cmd selects get, check or release.
// Result channel: done pulses for one cycle with result (ok, granted); the
// receiver cannot stall, so every result must be taken in that cycle.
// The accepting edge registers the item with the free map and stack top
// reads; the execute state then decides, makes its memory writes (free map,
// and the stack on a release) and registers done and result. busy is high
// until then, so a new item is taken only after the previous one is decided.
// Config channel: cfg_data (pool size) is written when cfg_valid and
// cfg_ready are high; cfg_ready is high while no command is in progress.
// A write empties the stack and restarts fresh numbering at 0.
// Reset: pool size 1024, stack empty, every number free. No clearing pass is
// needed: the free map is only trusted below the fresh-number counter, so the
// block accepts commands as soon as reset is released.
module id_allocator_free_stack_top #(
    parameter int CAPACITY = idalloc_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire idalloc_pkg::in_item_t               req,
    output logic                                     done,
    output idalloc_pkg::out_item_t                   result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [idalloc_pkg::NUM_COUNT_W-1:0] cfg_data
);

    idalloc_pkg::ctrl_t ctrl;

    idalloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .ctrl      (ctrl)
    );

    idalloc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .req      (req),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire
